// ===== sv/nrp_pkg.sv =====
package nrp_pkg;

  localparam int unsigned MAX_FRAC_DEFAULT = 5;
  localparam int unsigned HDR_LEN          = 6;

  localparam logic [2:0]  POS_DEAD   = 3'd7;
  localparam logic [2:0]  COMMA_MAX  = 3'd7;
  localparam logic [2:0]  FLD_LAT    = 3'd3;
  localparam logic [2:0]  FLD_LAT_HS = 3'd4;
  localparam logic [2:0]  FLD_LON    = 3'd5;
  localparam logic [2:0]  FLD_LON_HS = 3'd6;
  localparam logic [2:0]  E5_DIGITS  = 3'd5;
  localparam logic [31:0] MIN_PER_DEG = 32'd60;
  localparam logic [31:0] MIN_PER_DEG_RECIP = 32'd71582788;
  localparam logic [31:0] E5_SCALE    = 32'd100000;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LAST   = 8'h7a;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [1:0] {
    DSEL_DEG,
    DSEL_SCALE,
    DSEL_MIN
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     step;
    logic     use_nul;
    logic     clear;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_deg;
    logic     take_tmp;
    logic     mul_scale;
    logic     mul_deg;
    logic     store;
    logic     load_out;
  } nrp_cmd_t;

  typedef struct packed {
    logic conv_req;
    logic last;
    logic dx_big;
    logic div_done;
    logic div_busy;
  } nrp_status_t;

  function automatic logic [31:0] pow10(input logic [3:0] idx);
    logic [31:0] r;
    unique case (idx)
      4'd0:    r = 32'd1;
      4'd1:    r = 32'd10;
      4'd2:    r = 32'd100;
      4'd3:    r = 32'd1000;
      4'd4:    r = 32'd10000;
      4'd5:    r = 32'd100000;
      4'd6:    r = 32'd1000000;
      4'd7:    r = 32'd10000000;
      4'd8:    r = 32'd100000000;
      4'd9:    r = 32'd1000000000;
      default: r = 32'd1;
    endcase
    return r;
  endfunction

  // floor(2^32 / 10^idx), saturated to 2^32-1 for idx 0; never above the exact reciprocal
  function automatic logic [31:0] pow10_recip(input logic [3:0] idx);
    logic [31:0] r;
    unique case (idx)
      4'd0:    r = 32'hffffffff;
      4'd1:    r = 32'd429496729;
      4'd2:    r = 32'd42949672;
      4'd3:    r = 32'd4294967;
      4'd4:    r = 32'd429496;
      4'd5:    r = 32'd42949;
      4'd6:    r = 32'd4294;
      4'd7:    r = 32'd429;
      4'd8:    r = 32'd42;
      4'd9:    r = 32'd4;
      default: r = 32'hffffffff;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = CH_DOLLAR;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h4e;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4d;
      3'd5:    c = 8'h43;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/nrp_divider.sv =====
module nrp_divider
  import nrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  input  logic [31:0] recip,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic [31:0] x;
  logic [31:0] d;
  logic [31:0] rcp;
  logic [31:0] q;
  logic [31:0] r;
  logic [1:0]  phase;
  logic [31:0] q_est;
  logic [31:0] qd;

  // estimate is the true quotient or one below it
  assign q_est = 32'(({32'd0, x} * {32'd0, rcp}) >> 32);
  assign qd    = 32'(q * d);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= '0;
      end else if (busy) begin
        phase <= phase + 2'd1;
        if (phase == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= dividend;
      d   <= divisor;
      rcp <= recip;
    end else if (busy) begin
      unique case (phase)
        2'd0: begin
          q <= q_est;
        end
        2'd1: begin
          r <= x - qd;
        end
        default: begin
          if (r >= d) begin
            q <= q + 32'd1;
            r <= r - d;
          end
        end
      endcase
    end
  end

  assign quotient  = q;
  assign remainder = r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider done while still busy");

endmodule

// ===== sv/nrp_datapath.sv =====
module nrp_datapath
  import nrp_pkg::*;
#(
  parameter int unsigned MAX_FRACTION_DIGITS = MAX_FRAC_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  nrp_cmd_t    cmd,
  output nrp_status_t status,
  input  logic [7:0]  rx_byte,
  input  logic        last_byte,
  output logic [31:0] latitude_e5,
  output logic [31:0] longitude_e5,
  output logic [7:0]  lat_hemisphere,
  output logic [7:0]  lon_hemisphere,
  output logic        header_found
);

  localparam logic [2:0] FRAC_LIMIT = 3'(MAX_FRACTION_DIGITS);

  // input word
  logic [7:0] byte_q;
  logic       last_q;

  // parser state
  logic [2:0]  hdr_pos, hdr_pos_next;
  logic        hdr_seen, hdr_seen_next;
  logic [2:0]  comma_cnt, comma_cnt_next;
  logic        blocked, blocked_next;
  logic [31:0] acc, acc_next;
  logic [2:0]  frac_cnt, frac_cnt_next;
  logic        dot_seen, dot_seen_next;
  logic        illegal, illegal_next;
  logic [31:0] lat_st, lat_st_next;
  logic [31:0] lon_st, lon_st_next;
  logic [7:0]  lat_hs, lat_hs_next;
  logic [7:0]  lon_hs, lon_hs_next;

  // conversion
  logic [31:0] conv_val;
  logic [2:0]  conv_dx;
  logic        conv_lat;
  logic [31:0] deg;
  logic [31:0] tmp;

  logic [7:0]  b;
  logic        in_number;
  logic        bad;
  logic        conv_req;
  logic        zero_req;
  logic [31:0] acc_x10;

  logic        div_busy;
  logic        div_done;
  logic [31:0] div_q;
  logic [31:0] div_r;
  logic [31:0] div_a;
  logic [31:0] div_b;
  logic [31:0] div_c;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  assign b         = cmd.use_nul ? CH_NUL : byte_q;
  assign in_number = (comma_cnt == FLD_LAT) || (comma_cnt == FLD_LON);
  assign bad       = (b < CH_SPACE) || (b > CH_LAST);
  assign acc_x10   = {acc[28:0], 3'b000} + {acc[30:0], 1'b0};

  always_comb begin
    hdr_pos_next   = hdr_pos;
    hdr_seen_next  = hdr_seen;
    comma_cnt_next = comma_cnt;
    blocked_next   = blocked;
    acc_next       = acc;
    frac_cnt_next  = frac_cnt;
    dot_seen_next  = dot_seen;
    illegal_next   = illegal;
    lat_hs_next    = lat_hs;
    lon_hs_next    = lon_hs;
    conv_req       = 1'b0;
    zero_req       = 1'b0;
    if (cmd.clear) begin
      hdr_pos_next   = '0;
      hdr_seen_next  = 1'b0;
      comma_cnt_next = '0;
      blocked_next   = 1'b0;
      acc_next       = '0;
      frac_cnt_next  = '0;
      dot_seen_next  = 1'b0;
      illegal_next   = 1'b0;
    end else if (cmd.step) begin
      if (hdr_seen) begin
        if (!blocked) begin
          if (((comma_cnt == FLD_LAT_HS) || (comma_cnt == FLD_LON_HS)) && !dot_seen) begin
            if (comma_cnt == FLD_LAT_HS) begin
              lat_hs_next = b;
            end else begin
              lon_hs_next = b;
            end
            dot_seen_next = 1'b1;
          end
          if ((b == CH_STAR) || bad) begin
            if (in_number) begin
              conv_req = !bad && !illegal;
              zero_req = bad || illegal;
            end
            blocked_next = 1'b1;
          end else if (b == CH_COMMA) begin
            if (in_number) begin
              conv_req = !illegal;
              zero_req = illegal;
            end
            if (comma_cnt < COMMA_MAX) begin
              comma_cnt_next = comma_cnt + 3'd1;
            end
            acc_next      = '0;
            frac_cnt_next = '0;
            dot_seen_next = 1'b0;
            illegal_next  = 1'b0;
          end else if (in_number) begin
            if ((b >= CH_ZERO) && (b <= CH_NINE)) begin
              if (!dot_seen) begin
                acc_next = acc_x10 + {24'd0, b - CH_ZERO};
              end else if (frac_cnt < FRAC_LIMIT) begin
                acc_next      = acc_x10 + {24'd0, b - CH_ZERO};
                frac_cnt_next = frac_cnt + 3'd1;
              end
            end else if (b == CH_DOT) begin
              dot_seen_next = 1'b1;
            end else if (b != CH_MINUS) begin
              illegal_next = 1'b1;
            end
          end
        end
      end else if (hdr_pos != POS_DEAD) begin
        if (b == CH_NUL) begin
          hdr_pos_next = POS_DEAD;
        end else if ((hdr_pos < 3'(HDR_LEN)) && (b == hdr_char(hdr_pos))) begin
          hdr_pos_next = hdr_pos + 3'd1;
          if (hdr_pos == 3'(HDR_LEN - 1)) begin
            hdr_seen_next = 1'b1;
          end
        end else begin
          hdr_pos_next = (b == CH_DOLLAR) ? 3'd1 : 3'd0;
        end
      end
    end
  end

  always_comb begin
    lat_st_next = lat_st;
    lon_st_next = lon_st;
    if (zero_req) begin
      if (comma_cnt == FLD_LAT) begin
        lat_st_next = '0;
      end else begin
        lon_st_next = '0;
      end
    end else if (cmd.store) begin
      if (conv_lat) begin
        lat_st_next = 32'(deg + tmp);
      end else begin
        lon_st_next = 32'(deg + tmp);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos   <= '0;
      hdr_seen  <= 1'b0;
      comma_cnt <= '0;
      blocked   <= 1'b0;
      acc       <= '0;
      frac_cnt  <= '0;
      dot_seen  <= 1'b0;
      illegal   <= 1'b0;
      lat_st    <= '0;
      lon_st    <= '0;
      lat_hs    <= '0;
      lon_hs    <= '0;
    end else begin
      hdr_pos   <= hdr_pos_next;
      hdr_seen  <= hdr_seen_next;
      comma_cnt <= comma_cnt_next;
      blocked   <= blocked_next;
      acc       <= acc_next;
      frac_cnt  <= frac_cnt_next;
      dot_seen  <= dot_seen_next;
      illegal   <= illegal_next;
      lat_st    <= lat_st_next;
      lon_st    <= lon_st_next;
      lat_hs    <= lat_hs_next;
      lon_hs    <= lon_hs_next;
    end
  end

  // divider and multiplier operands
  always_comb begin
    unique case (cmd.div_sel)
      DSEL_DEG: begin
        div_a = conv_val;
        div_b = pow10(4'({1'b0, conv_dx} + 4'd2));
        div_c = pow10_recip(4'({1'b0, conv_dx} + 4'd2));
      end
      DSEL_SCALE: begin
        div_a = tmp;
        div_b = pow10(4'({1'b0, conv_dx} - {1'b0, E5_DIGITS}));
        div_c = pow10_recip(4'({1'b0, conv_dx} - {1'b0, E5_DIGITS}));
      end
      default: begin
        div_a = tmp;
        div_b = MIN_PER_DEG;
        div_c = MIN_PER_DEG_RECIP;
      end
    endcase
  end

  assign mul_a = cmd.mul_deg ? deg : tmp;
  assign mul_b = cmd.mul_deg ? E5_SCALE : pow10(4'({1'b0, E5_DIGITS} - {1'b0, conv_dx}));
  assign mul_p = mul_a * mul_b;

  nrp_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .recip     (div_c),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_q <= rx_byte;
      last_q <= last_byte;
    end
    if (conv_req) begin
      conv_val <= acc;
      conv_dx  <= frac_cnt;
      conv_lat <= (comma_cnt == FLD_LAT);
    end
    if (cmd.take_deg) begin
      deg <= div_q;
      tmp <= div_r;
    end else if (cmd.take_tmp) begin
      tmp <= div_q;
    end else if (cmd.mul_scale) begin
      tmp <= mul_p[31:0];
    end
    if (cmd.mul_deg) begin
      deg <= mul_p[31:0];
    end
    if (cmd.load_out) begin
      latitude_e5    <= lat_st;
      longitude_e5   <= lon_st;
      lat_hemisphere <= lat_hs;
      lon_hemisphere <= lon_hs;
      header_found   <= hdr_seen;
    end
  end

  assign status.conv_req = conv_req;
  assign status.last     = last_q;
  assign status.dx_big   = conv_dx > E5_DIGITS;
  assign status.div_done = div_done;
  assign status.div_busy = div_busy;

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> !hdr_seen && (comma_cnt == '0) && !blocked)
    else $error("sentence state not cleared");

endmodule

// ===== sv/nrp_ctrl.sv =====
module nrp_ctrl
  import nrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  nrp_status_t status,
  output nrp_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_BYTE    = 4'd1;
  localparam logic [3:0] S_DIV1_GO = 4'd2;
  localparam logic [3:0] S_DIV1_W  = 4'd3;
  localparam logic [3:0] S_SCALE   = 4'd4;
  localparam logic [3:0] S_DIV2_W  = 4'd5;
  localparam logic [3:0] S_DIV3_GO = 4'd6;
  localparam logic [3:0] S_DIV3_W  = 4'd7;
  localparam logic [3:0] S_MULDEG  = 4'd8;
  localparam logic [3:0] S_ADD     = 4'd9;
  localparam logic [3:0] S_NUL     = 4'd10;
  localparam logic [3:0] S_LOAD    = 4'd11;

  logic [3:0] state, state_next;
  logic       out_valid_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DSEL_DEG;
    unique case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = S_BYTE;
        end
      end
      S_BYTE: begin
        cmd.step = 1'b1;
        if (status.conv_req) begin
          state_next = S_DIV1_GO;
        end else if (status.last) begin
          state_next = S_NUL;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV1_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_DEG;
        state_next    = S_DIV1_W;
      end
      S_DIV1_W: begin
        if (status.div_done) begin
          cmd.take_deg = 1'b1;
          state_next   = S_SCALE;
        end
      end
      S_SCALE: begin
        if (status.dx_big) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_SCALE;
          state_next    = S_DIV2_W;
        end else begin
          cmd.mul_scale = 1'b1;
          state_next    = S_DIV3_GO;
        end
      end
      S_DIV2_W: begin
        if (status.div_done) begin
          cmd.take_tmp = 1'b1;
          state_next   = S_DIV3_GO;
        end
      end
      S_DIV3_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_MIN;
        state_next    = S_DIV3_W;
      end
      S_DIV3_W: begin
        if (status.div_done) begin
          cmd.take_tmp = 1'b1;
          state_next   = S_MULDEG;
        end
      end
      S_MULDEG: begin
        cmd.mul_deg = 1'b1;
        state_next  = S_ADD;
      end
      S_ADD: begin
        cmd.store  = 1'b1;
        state_next = status.last ? S_NUL : S_IDLE;
      end
      S_NUL: begin
        cmd.step    = 1'b1;
        cmd.use_nul = 1'b1;
        state_next  = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy)
    else $error("divider started while busy");

  a_accept_steps: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_BYTE)
    else $error("accepted word not processed");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

endmodule

// ===== sv/nmea_rmc_position_parser_top.sv =====
// channel | signals                         | word
// --------+---------------------------------+---------------------------------------------
// in      | in_valid, in_ready              | rx_byte, last_byte
// out     | out_valid, out_ready            | latitude_e5, longitude_e5, lat_hemisphere,
//         |                                 | lon_hemisphere, header_found
//
// a plain byte is accepted, then gets one parser update
// a byte closing a valid latitude or longitude field adds a conversion that runs the reciprocal
// divider two times, or three times with more than five fraction digits kept
// a last byte adds the end-of-sentence step and the output load
// rst is synchronous and clears the parser and the stored position to zero
// a result waits in the output register; the next last byte stalls until it is taken
module nmea_rmc_position_parser_top
  import nrp_pkg::*;
#(
  parameter int unsigned MAX_FRACTION_DIGITS = MAX_FRAC_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] latitude_e5,
  output logic [31:0] longitude_e5,
  output logic [7:0]  lat_hemisphere,
  output logic [7:0]  lon_hemisphere,
  output logic        header_found
);

  nrp_cmd_t    cmd;
  nrp_status_t status;

  nrp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  nrp_datapath #(
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .rx_byte        (rx_byte),
    .last_byte      (last_byte),
    .latitude_e5    (latitude_e5),
    .longitude_e5   (longitude_e5),
    .lat_hemisphere (lat_hemisphere),
    .lon_hemisphere (lon_hemisphere),
    .header_found   (header_found)
  );

endmodule
